// ----- hw/rtl/gtcw_pkg.sv -----
package gtcw_pkg;

  localparam int unsigned GlyphCount = 96;
  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] FirstGlyph  = 7'd32;
  localparam logic [6:0] LastPageSel = 7'd8;
  localparam logic [7:0] PageCmd     = 8'hB8;
  localparam logic [7:0] ColumnCmd   = 8'h40;

  // steps of the write sequencer
  localparam logic [3:0] StepLastGlyph = 4'd7;
  localparam logic [3:0] StepLastRepos = 4'd11;
  localparam logic [3:0] StepReposBase = 4'd8;

  typedef enum logic {
    OP_REPOS,
    OP_GLYPH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       half;
    logic [6:0] glyph;
    logic [2:0] page;
    logic       repos_after;
  } cmd_t;

  // five column bytes per glyph, first column in the top byte
  localparam logic [39:0] Glyphs [GlyphCount] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0030300000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
  };

endpackage

// ----- hw/rtl/gtcw_front.sv -----
module gtcw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [6:0]      char_code_i,
  output logic            enq_o,
  output gtcw_pkg::cmd_t  cmd_o
);
  import gtcw_pkg::*;

  logic [3:0] chars_q, chars_d;
  logic [2:0] page_q, page_d;
  logic       is_page_sel, is_glyph, line_full;
  logic [6:0] glyph_idx;

  assign is_page_sel = (char_code_i <= LastPageSel);
  assign is_glyph    = (char_code_i >= FirstGlyph);
  assign glyph_idx   = char_code_i - FirstGlyph;
  assign line_full   = (chars_q == 4'hF);

  always_comb begin
    chars_d = chars_q;
    page_d  = page_q;
    cmd_o   = '{op: OP_REPOS, half: 1'b0, glyph: glyph_idx, page: page_q, repos_after: 1'b0};
    if (is_page_sel) begin
      // code 0 wraps round to page 7
      page_d     = char_code_i[2:0] - 3'd1;
      chars_d    = '0;
      cmd_o.page = page_d;
    end else if (is_glyph) begin
      cmd_o.op   = OP_GLYPH;
      cmd_o.half = chars_q[3];
      chars_d    = chars_q + 4'd1;
      if (line_full) begin
        page_d            = page_q + 3'd1;
        cmd_o.repos_after = 1'b1;
        cmd_o.page        = page_d;
      end
    end
  end

  assign enq_o = accept_i && (is_page_sel || is_glyph);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      page_q  <= '0;
    end else if (accept_i) begin
      chars_q <= chars_d;
      page_q  <= page_d;
    end
  end

endmodule

// ----- hw/rtl/gtcw_queue.sv -----
module gtcw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enq_i,
  input  gtcw_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            deq_i,
  output logic            valid_o,
  output gtcw_pkg::cmd_t  cmd_o
);
  import gtcw_pkg::*;

  cmd_t       mem_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(QueueDepth));
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (enq_i && !deq_i) begin
      count_d = count_q + 2'd1;
    end else if (deq_i && !enq_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (enq_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enq_i && full_o))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(deq_i && !valid_o))
    else $error("queue read while empty");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'(QueueDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- hw/rtl/gtcw_back.sv -----
module gtcw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  gtcw_pkg::cmd_t  cmd_i,
  output logic            deq_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            half_select_o,
  output logic            is_data_o,
  output logic [7:0]      write_byte_o,
  output logic            last_write_o
);
  import gtcw_pkg::*;

  logic [3:0] step_q;
  logic       out_valid_q;
  logic       out_half_q, out_data_q, out_last_q;
  logic [7:0] out_byte_q;

  logic       advance;
  logic       wr_half, wr_data, wr_last;
  logic [7:0] wr_byte;
  logic [1:0] repos_step;
  logic [39:0] glyph_row;

  assign advance    = cmd_valid_i && (!out_valid_q || pop_i);
  assign glyph_row  = Glyphs[cmd_i.glyph];
  assign repos_step = (cmd_i.op == OP_GLYPH) ? 2'(step_q - StepReposBase) : step_q[1:0];

  always_comb begin
    wr_half = cmd_i.half;
    wr_data = 1'b1;
    wr_byte = 8'h00;
    wr_last = 1'b0;
    if (cmd_i.op == OP_GLYPH && step_q <= StepLastGlyph) begin
      case (step_q)
        4'd0:    wr_byte = glyph_row[39:32];
        4'd1:    wr_byte = glyph_row[31:24];
        4'd2:    wr_byte = glyph_row[23:16];
        4'd3:    wr_byte = glyph_row[15:8];
        4'd4:    wr_byte = glyph_row[7:0];
        default: wr_byte = 8'h00;
      endcase
      wr_last = (step_q == StepLastGlyph) && !cmd_i.repos_after;
    end else begin
      // page to both halves, then column 0 to both halves
      wr_data = 1'b0;
      wr_half = repos_step[0];
      wr_byte = repos_step[1] ? ColumnCmd : (PageCmd | {5'd0, cmd_i.page});
      wr_last = (repos_step == 2'd3);
    end
  end

  assign deq_o = advance && wr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q      <= wr_last ? 4'd0 : step_q + 4'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_half_q <= wr_half;
      out_data_q <= wr_data;
      out_byte_q <= wr_byte;
      out_last_q <= wr_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign half_select_o = out_half_q;
  assign is_data_o     = out_data_q;
  assign write_byte_o  = out_byte_q;
  assign last_write_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLastRepos)
    else $error("sequencer step out of range");
  a_step_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 4'd0) |-> cmd_valid_i)
    else $error("sequencer mid-command with no command queued");
  a_data_last_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q && out_data_q) |-> (out_byte_q == 8'h00))
    else $error("final data word of a glyph is not a blank column");
`endif

endmodule

// ----- hw/rtl/glcd_text_character_writer_top.sv -----
// Text terminal front end for a 128x64 panel made of two 64-column controller
// halves. Each character word pushed in becomes a run of controller writes
// popped out one per cycle while pop is held: a page-select code (0..8)
// gives four command writes, a printable code (32..127) gives eight data
// writes (five glyph columns and three blank ones), plus four command writes
// when it completes a 16-character line; codes 9..31 give nothing. A
// character is classified by the front end and queued as it is accepted, so
// input is accepted while the previous character's writes are still going
// out; the sustained rate is set by the write sequencer, which issues one
// write per cycle while pop is held.
module glcd_text_character_writer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [6:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic       half_select_o,
  output logic       is_data_o,
  output logic [7:0] write_byte_o,
  output logic       last_write_o
);
  import gtcw_pkg::*;

  logic accept, enq, deq, q_full, q_valid;
  cmd_t enq_cmd, head_cmd;

  assign full   = q_full;
  assign accept = push && !q_full;

  gtcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .enq_o       (enq),
    .cmd_o       (enq_cmd)
  );

  gtcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .cmd_i   (enq_cmd),
    .full_o  (q_full),
    .deq_i   (deq),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  gtcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (head_cmd),
    .deq_o         (deq),
    .empty_o       (empty),
    .pop_i         (pop),
    .half_select_o (half_select_o),
    .is_data_o     (is_data_o),
    .write_byte_o  (write_byte_o),
    .last_write_o  (last_write_o)
  );

endmodule

// ----- bench/glcd_text_character_writer_top_tb.sv -----
module glcd_text_character_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gtcw_pkg::*;

  typedef struct packed {
    logic       half;
    logic       data;
    logic [7:0] wbyte;
    logic       last;
  } disp_write_t;

  // 5x7 font, first column in the top byte
  localparam logic [39:0] FontCols [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0030300000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
  };

  // page 7 select followed by a full line wraps back to page 0
  localparam logic [6:0] DirCodes [25] = '{
    7'd127, 7'd32, 7'd9, 7'd31, 7'd0, 7'd33, 7'd1, 7'd126, 7'd8,
    7'd72, 7'd101, 7'd108, 7'd108, 7'd111, 7'd32, 7'd87, 7'd111,
    7'd114, 7'd108, 7'd100, 7'd33, 7'd126, 7'd48, 7'd57, 7'd127
  };

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [6:0] char_code;
  logic       empty;
  logic       pop;
  logic       half_select;
  logic       is_data;
  logic [7:0] write_byte;
  logic       last_write;

  logic [6:0]  char_q[$];
  disp_write_t write_q[$];
  logic [3:0]  line_chars;
  logic [2:0]  cur_page;
  int          send_idle;
  int          recv_idle;
  int          fail_count;
  bit          took;

  glcd_text_character_writer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code),
    .empty        (empty),
    .pop          (pop),
    .half_select_o(half_select),
    .is_data_o    (is_data),
    .write_byte_o (write_byte),
    .last_write_o (last_write)
  );

  always #4 clk_i = ~clk_i;

  function automatic void add_write(logic half, logic data, logic [7:0] wbyte);
    disp_write_t w;
    w = '{half, data, wbyte, 1'b0};
    write_q.push_back(w);
  endfunction

  function automatic void add_reposition();
    add_write(1'b0, 1'b0, PageCmd | {5'd0, cur_page});
    add_write(1'b1, 1'b0, PageCmd | {5'd0, cur_page});
    add_write(1'b0, 1'b0, ColumnCmd);
    add_write(1'b1, 1'b0, ColumnCmd);
  endfunction

  // expected display writes for one character word
  function automatic void render_char(logic [6:0] code);
    int          first;
    int          idx;
    logic        half;
    logic [7:0]  col;
    disp_write_t w;
    first = write_q.size();
    if (code <= LastPageSel) begin
      cur_page   = code[2:0] - 3'd1;
      line_chars = 4'd0;
      add_reposition();
    end else if (code >= FirstGlyph) begin
      idx  = int'(code - FirstGlyph);
      half = line_chars[3];
      for (int k = 0; k < 8; k++) begin
        col = (k < 5) ? FontCols[idx][39 - 8 * k -: 8] : 8'h00;
        add_write(half, 1'b1, col);
      end
      line_chars = line_chars + 4'd1;
      // counter wrapped: sixteenth character ends the line
      if (line_chars == 4'd0) begin
        cur_page = cur_page + 3'd1;
        add_reposition();
      end
    end
    if (write_q.size() > first) begin
      w = write_q.pop_back();
      w.last = 1'b1;
      write_q.push_back(w);
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    bit go;
    go = 1'b0;
    if (rst_ni) begin
      if (push && !took) begin
        go = 1'b1;
      end else if (char_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        go = 1'b1;
        char_code <= char_q[0];
      end else begin
        char_code <= 7'($urandom);
      end
    end
    push <= go;
  end

  always @(posedge clk_i) begin
    took = 1'b0;
    if (rst_ni && push && !full) begin
      took = 1'b1;
      void'(char_q.pop_front());
      render_char(char_code);
    end
  end

  // monitor
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    disp_write_t got_w;
    disp_write_t exp_w;
    if (rst_ni && pop && !empty) begin
      got_w = '{half_select, is_data, write_byte, last_write};
      if (write_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected write: half=%0d data=%0d byte=%02h last=%0d",
                   got_w.half, got_w.data, got_w.wbyte, got_w.last);
      end else begin
        exp_w = write_q.pop_front();
        if (got_w.half !== exp_w.half || got_w.data !== exp_w.data ||
            got_w.wbyte !== exp_w.wbyte || got_w.last !== exp_w.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch exp h=%0d d=%0d b=%02h l=%0d got h=%0d d=%0d b=%02h l=%0d",
                     exp_w.half, exp_w.data, exp_w.wbyte, exp_w.last,
                     got_w.half, got_w.data, got_w.wbyte, got_w.last);
        end
      end
    end
  end

  initial begin
    int         n;
    int         r;
    logic [6:0] c;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    char_code  = '0;
    line_chars = '0;
    cur_page   = '0;
    fail_count = 0;
    took       = 1'b0;
    send_idle  = 27;
    recv_idle  = 46;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirCodes[i]) char_q.push_back(DirCodes[i]);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 46;
        recv_idle = 27;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      // mostly printable so lines fill and wrap, some page selects and noise
      n = 0;
      while (n < 22) begin
        r = $urandom_range(0, 99);
        if (r < 76) c = 7'($urandom_range(32, 127));
        else if (r < 90) c = 7'($urandom_range(0, 8));
        else c = 7'($urandom_range(9, 31));
        if (c <= LastPageSel || c >= FirstGlyph) n++;
        char_q.push_back(c);
      end
      while (char_q.size() != 0 || write_q.size() != 0) @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && write_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
